[rtl/core/tga_rle_pkg.sv]
// Shared types and constants for the Targa true-colour RLE decoder.
`timescale 1ns / 1ps
`default_nettype none

package tga_rle_pkg;

  // Accepted range of image sides, inclusive.
  localparam logic [15:0] MIN_SIDE = 16'd16;
  localparam logic [15:0] MAX_SIDE = 16'd4096;

  // Pixel depth codes.
  localparam logic [1:0] DEPTH_15 = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;
  localparam logic [1:0] DEPTH_24 = 2'd2;
  localparam logic [1:0] DEPTH_32 = 2'd3;

  // Result status codes.
  localparam logic STATUS_RUN      = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // Entries in the queue between the parser and the colour stage.
  localparam int unsigned QUEUE_DEPTH = 4;

  // One classified result: position, raw pixel word and how to expand it.
  typedef struct packed {
    logic        status;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  run_length;
    logic [31:0] pixel;
    logic [1:0]  depth;
    logic        last_of_image;
  } evt_t;

endpackage

`default_nettype wire

[rtl/core/tga_rle_if.sv]
// Stream interfaces for file bytes in and pixel runs out.
`timescale 1ns / 1ps
`default_nettype none

interface tga_rle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface tga_rle_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [7:0]  run_length;
  logic [7:0]  alpha;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_of_image;

  modport source (output valid, output status, output pos_x, output pos_y,
                  output run_length, output alpha, output red, output green,
                  output blue, output last_of_image, input ready);
  modport sink   (input valid, input status, input pos_x, input pos_y,
                  input run_length, input alpha, input red, input green,
                  input blue, input last_of_image, output ready);
endinterface

`default_nettype wire

[rtl/core/tga_rle_front.sv]
// Byte parser: header, ID skip, packets, pixel assembly and run positions.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  tga_rle_in_if.sink          in_i,
  input  wire logic           queue_full_i,
  output logic                push_o,
  output tga_rle_pkg::evt_t   evt_o
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_PACKET = 3'd2;
  localparam logic [2:0] PH_PIXEL  = 3'd3;
  localparam logic [2:0] PH_IDLE   = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [4:0]  hdr_idx_q, hdr_idx_d;
  logic        hdr_bad_q, hdr_bad_d;
  logic [7:0]  id_skip_q, id_skip_d;
  logic        is_rle_q, is_rle_d;
  logic [1:0]  depth_q, depth_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [7:0]  pkt_left_q, pkt_left_d;
  logic        pkt_rep_q, pkt_rep_d;
  logic [23:0] pix_q, pix_d;
  logic [1:0]  pix_idx_q, pix_idx_d;

  logic        accept;
  logic [7:0]  b;
  logic [2:0]  ph;
  logic [4:0]  hi;
  logic        bad;
  logic [1:0]  last_idx;
  logic [31:0] word;
  logic [15:0] rem;
  logic [7:0]  run_len;
  logic [16:0] col_end;
  logic        row_end;
  logic [15:0] col_new;
  logic        pkt_done;

  assign in_i.ready = ~queue_full_i;
  assign accept     = in_i.valid & ~queue_full_i;
  assign b          = in_i.data_byte;

  // A start-of-file byte is header byte zero whatever came before.
  assign ph  = in_i.start_of_file ? PH_HEADER : phase_q;
  assign hi  = in_i.start_of_file ? 5'd0 : hdr_idx_q;
  assign bad = in_i.start_of_file ? 1'b0 : hdr_bad_q;

  assign last_idx = (depth_q == tga_rle_pkg::DEPTH_15 ||
                     depth_q == tga_rle_pkg::DEPTH_16) ? 2'd1 : depth_q;

  // Completed pixel word: stored bytes below the current index, this byte on top.
  always_comb begin
    word = '0;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < pix_idx_q) word[8*k +: 8] = pix_q[8*k +: 8];
    end
    word[{pix_idx_q, 3'b000} +: 8] = b;
  end

  // Run length of a repeat packet, clipped at the row end.
  assign rem     = width_q - col_q;
  assign run_len = ({8'd0, pkt_left_q} < rem) ? pkt_left_q : rem[7:0];

  always_comb begin
    if (is_rle_q && pkt_rep_q) begin
      col_end = {1'b0, col_q} + {9'd0, run_len};
    end else begin
      col_end = {1'b0, col_q} + 17'd1;
    end
  end
  assign row_end = col_end >= {1'b0, width_q};

  always_comb begin
    phase_d    = phase_q;
    hdr_idx_d  = hdr_idx_q;
    hdr_bad_d  = hdr_bad_q;
    id_skip_d  = id_skip_q;
    is_rle_d   = is_rle_q;
    depth_d    = depth_q;
    width_d    = width_q;
    height_d   = height_q;
    col_d      = col_q;
    row_d      = row_q;
    pkt_left_d = pkt_left_q;
    pkt_rep_d  = pkt_rep_q;
    pix_d      = pix_q;
    pix_idx_d  = pix_idx_q;
    col_new    = col_q;
    pkt_done   = 1'b0;
    push_o     = 1'b0;

    evt_o               = '0;
    evt_o.status        = tga_rle_pkg::STATUS_RUN;
    evt_o.pos_x         = col_q[11:0];
    evt_o.pos_y         = row_q[11:0];
    evt_o.run_length    = 8'd1;
    evt_o.pixel         = word;
    evt_o.depth         = depth_q;
    evt_o.last_of_image = row_end && (row_q == 16'd0);

    if (accept) begin
      unique case (ph)
        PH_HEADER: begin
          hdr_bad_d = bad;
          hdr_idx_d = hi;
          case (hi)
            5'd0: id_skip_d = b;
            5'd1: if (b != 8'd0) hdr_bad_d = 1'b1;
            5'd2: begin
              if (b == 8'd2) is_rle_d = 1'b0;
              else if (b == 8'd10) is_rle_d = 1'b1;
              else hdr_bad_d = 1'b1;
            end
            5'd12: width_d  = {8'd0, b};
            5'd13: width_d  = {b, width_q[7:0]};
            5'd14: height_d = {8'd0, b};
            5'd15: height_d = {b, height_q[7:0]};
            5'd16: begin
              if (b == 8'd15) depth_d = tga_rle_pkg::DEPTH_15;
              else if (b == 8'd16) depth_d = tga_rle_pkg::DEPTH_16;
              else if (b == 8'd24) depth_d = tga_rle_pkg::DEPTH_24;
              else if (b == 8'd32) depth_d = tga_rle_pkg::DEPTH_32;
              else hdr_bad_d = 1'b1;
            end
            default: ;
          endcase
          if (hi < 5'd17) begin
            hdr_idx_d = hi + 5'd1;
            phase_d   = PH_HEADER;
          end else if (bad || width_q < tga_rle_pkg::MIN_SIDE ||
                       width_q > tga_rle_pkg::MAX_SIDE ||
                       height_q < tga_rle_pkg::MIN_SIDE ||
                       height_q > tga_rle_pkg::MAX_SIDE) begin
            phase_d = PH_IDLE;
            push_o  = 1'b1;
            evt_o   = '0;
            evt_o.status = tga_rle_pkg::STATUS_REJECTED;
          end else begin
            col_d     = '0;
            row_d     = height_q - 16'd1;
            pix_idx_d = '0;
            if (id_skip_q != 8'd0) phase_d = PH_SKIP;
            else phase_d = is_rle_q ? PH_PACKET : PH_PIXEL;
          end
        end

        PH_SKIP: begin
          id_skip_d = id_skip_q - 8'd1;
          if (id_skip_q == 8'd1) begin
            pix_idx_d = '0;
            phase_d   = is_rle_q ? PH_PACKET : PH_PIXEL;
          end
        end

        PH_PACKET: begin
          pkt_rep_d  = b[7];
          pkt_left_d = {1'b0, b[6:0]} + 8'd1;
          pix_idx_d  = '0;
          phase_d    = PH_PIXEL;
        end

        PH_PIXEL: begin
          if (pix_idx_q != last_idx) begin
            pix_d[{pix_idx_q, 3'b000} +: 8] = b;
            pix_idx_d = pix_idx_q + 2'd1;
          end else begin
            pix_idx_d = '0;
            if (!is_rle_q) begin
              push_o   = 1'b1;
              col_new  = col_end[15:0];
              pkt_done = 1'b1;
            end else if (pkt_rep_q) begin
              push_o           = 1'b1;
              evt_o.run_length = run_len;
              col_new          = col_end[15:0];
              pkt_left_d       = '0;
              pkt_done         = 1'b1;
              phase_d          = PH_PACKET;
            end else begin
              // Raw packet: pixels past the row end are read and dropped.
              if (col_q < width_q) begin
                push_o  = 1'b1;
                col_new = col_end[15:0];
              end
              pkt_left_d = pkt_left_q - 8'd1;
              if (pkt_left_q == 8'd1) begin
                pkt_done = 1'b1;
                phase_d  = PH_PACKET;
              end
            end
            col_d = col_new;
            if (pkt_done && col_new >= width_q) begin
              if (row_q == 16'd0) begin
                phase_d = PH_IDLE;
              end else begin
                row_d = row_q - 16'd1;
                col_d = '0;
              end
            end
          end
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hdr_idx_q  <= '0;
      hdr_bad_q  <= 1'b0;
      id_skip_q  <= '0;
      is_rle_q   <= 1'b0;
      depth_q    <= tga_rle_pkg::DEPTH_15;
      width_q    <= '0;
      height_q   <= '0;
      col_q      <= '0;
      row_q      <= '0;
      pkt_left_q <= '0;
      pkt_rep_q  <= 1'b0;
      pix_idx_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      hdr_idx_q  <= hdr_idx_d;
      hdr_bad_q  <= hdr_bad_d;
      id_skip_q  <= id_skip_d;
      is_rle_q   <= is_rle_d;
      depth_q    <= depth_d;
      width_q    <= width_d;
      height_q   <= height_d;
      col_q      <= col_d;
      row_q      <= row_d;
      pkt_left_q <= pkt_left_d;
      pkt_rep_q  <= pkt_rep_d;
      pix_idx_q  <= pix_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

endmodule

`default_nettype wire

[rtl/core/tga_rle_queue.sv]
// Small register queue between the parser and the colour stage.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  tga_rle_pkg::evt_t       push_evt_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    head_valid_o,
  output tga_rle_pkg::evt_t       head_evt_o
);

  localparam int unsigned Depth = tga_rle_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tga_rle_pkg::evt_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o       = count_q == CntW'(Depth);
  assign head_valid_o = count_q != '0;
  assign head_evt_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) count_d = count_q + CntW'(1);
    else if (!do_push && do_pop) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_evt_i;
  end

endmodule

`default_nettype wire

[rtl/core/tga_rle_back.sv]
// Colour stage: expands the raw pixel word to ARGB into the output register.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               head_valid_i,
  input  tga_rle_pkg::evt_t       head_evt_i,
  output logic                    pop_o,
  tga_rle_out_if.source           out_o
);

  logic        valid_q;
  logic        load;
  logic [7:0]  a_d, r_d, g_d, b_d;
  logic [31:0] t;

  assign t     = head_evt_i.pixel;
  assign load  = head_valid_i & (~valid_q | out_o.ready);
  assign pop_o = load;

  always_comb begin
    if (head_evt_i.status == tga_rle_pkg::STATUS_REJECTED) begin
      a_d = '0;
      r_d = '0;
      g_d = '0;
      b_d = '0;
    end else if (head_evt_i.depth == tga_rle_pkg::DEPTH_15 ||
                 head_evt_i.depth == tga_rle_pkg::DEPTH_16) begin
      r_d = {t[14:10], 3'b000};
      g_d = {t[9:5], 3'b000};
      b_d = {t[4:0], 3'b000};
      a_d = (head_evt_i.depth == tga_rle_pkg::DEPTH_16 && t[15]) ? 8'h00 : 8'hff;
    end else begin
      b_d = t[7:0];
      g_d = t[15:8];
      r_d = t[23:16];
      a_d = (head_evt_i.depth == tga_rle_pkg::DEPTH_32) ? t[31:24] : 8'hff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_o.status        <= head_evt_i.status;
      out_o.pos_x         <= head_evt_i.pos_x;
      out_o.pos_y         <= head_evt_i.pos_y;
      out_o.run_length    <= head_evt_i.run_length;
      out_o.last_of_image <= head_evt_i.last_of_image;
      out_o.alpha         <= a_d;
      out_o.red           <= r_d;
      out_o.green         <= g_d;
      out_o.blue          <= b_d;
    end
  end

  assign out_o.valid = valid_q;

endmodule

`default_nettype wire

[rtl/core/tga_truecolor_rle_decoder_unit.sv]
// Top level of the Targa true-colour RLE decoder.
// Usage: file bytes arrive on in_i, one transfer per byte, with start_of_file
// set on the first byte of each file so that the header parse restarts.
// Pixel runs and header rejections leave on out_o, one transfer per result;
// a byte causes at most one result, and many bytes cause none.
// The parser takes one byte per cycle whenever the four-entry queue behind
// it has room, so a stream sustains one byte per clock cycle.
// A result is written into the queue in the same cycle as the byte that
// completes it is transferred, and from there it is loaded into the output
// register that drives out_o.
// When the receiver stalls, the output register holds its result, the queue
// fills behind it, and in_i.ready falls once the queue is full; nothing is
// lost and the parser resumes as soon as a queue entry frees up.
// Reset empties the queue and output register and returns the parser to
// the header phase, so bytes after reset are read as a header.
// After a rejection or the last run of an image, bytes are ignored until the
// next start_of_file.
`timescale 1ns / 1ps
`default_nettype none

module tga_truecolor_rle_decoder_unit (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  tga_rle_in_if.sink     in_i,
  tga_rle_out_if.source  out_o
);

  logic              push;
  tga_rle_pkg::evt_t push_evt;
  logic              queue_full;
  logic              pop;
  logic              head_valid;
  tga_rle_pkg::evt_t head_evt;

  // Front: classifies bytes and forms one event per result.
  tga_rle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .evt_o        (push_evt)
  );

  // Queue: decouples the parser from output stalls.
  tga_rle_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_evt_i   (push_evt),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_evt_o   (head_evt)
  );

  // Back: expands colours and holds the result for the receiver.
  tga_rle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_evt_i   (head_evt),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

[verif/tga_file_pkg.sv]
// Targa file layout constants shared by the decoder testbench files.
`timescale 1ns / 1ps

package tga_file_pkg;

  // Byte offsets within the 18-byte file header.
  localparam int unsigned HDR_ID_LEN    = 0;
  localparam int unsigned HDR_CMAP_TYPE = 1;
  localparam int unsigned HDR_IMG_TYPE  = 2;
  localparam int unsigned HDR_WIDTH_LO  = 12;
  localparam int unsigned HDR_WIDTH_HI  = 13;
  localparam int unsigned HDR_HEIGHT_LO = 14;
  localparam int unsigned HDR_HEIGHT_HI = 15;
  localparam int unsigned HDR_DEPTH     = 16;
  localparam int unsigned HDR_LAST      = 17;
  localparam int unsigned HDR_BYTES     = 18;

  // Colour map type and image type codes.
  localparam logic [7:0] CMAP_NONE    = 8'd0;
  localparam logic [7:0] CMAP_PRESENT = 8'd1;
  localparam logic [7:0] TYPE_PLAIN   = 8'd2;
  localparam logic [7:0] TYPE_GREY    = 8'd3;
  localparam logic [7:0] TYPE_RLE     = 8'd10;

  // Bits per pixel as written in the header.
  localparam logic [7:0] BITS_8  = 8'd8;
  localparam logic [7:0] BITS_15 = 8'd15;
  localparam logic [7:0] BITS_16 = 8'd16;
  localparam logic [7:0] BITS_24 = 8'd24;
  localparam logic [7:0] BITS_32 = 8'd32;

endpackage

[verif/tga_run_checker.sv]
// Decodes the observed byte stream itself and checks every pixel run that leaves the block.
`timescale 1ns / 1ps

module tga_run_checker
  import tga_rle_pkg::*;
  import tga_file_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tga_rle_in_if       in_mon,
  tga_rle_out_if      out_mon,
  output int unsigned fail_count_o,
  output int unsigned runs_waiting_o
);

  typedef enum logic [2:0] {
    DEC_HEADER,
    DEC_SKIP_ID,
    DEC_PACKET,
    DEC_PIXEL,
    DEC_DONE
  } dec_phase_e;

  typedef struct packed {
    logic        status;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  run_length;
    logic [7:0]  alpha;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_of_image;
  } run_t;

  dec_phase_e  phase;
  logic [4:0]  hdr_idx;
  logic [7:0]  id_left;
  logic        rle;
  logic [1:0]  depth;
  logic [15:0] width;
  logic [15:0] height;
  logic [15:0] col;
  logic [15:0] row;
  logic [7:0]  pkt_left;
  logic        pkt_run;
  logic [31:0] pix_word;
  logic [2:0]  pix_idx;
  logic        hdr_bad;

  run_t        expected_runs[$];
  int unsigned fails = 0;

  task automatic clear_decoder();
    phase    = DEC_HEADER;
    hdr_idx  = '0;
    id_left  = '0;
    rle      = 1'b0;
    depth    = DEPTH_15;
    width    = '0;
    height   = '0;
    col      = '0;
    row      = '0;
    pkt_left = '0;
    pkt_run  = 1'b0;
    pix_word = '0;
    pix_idx  = '0;
    hdr_bad  = 1'b0;
  endtask

  function automatic string describe(run_t r);
    return $sformatf("st=%0d x=%0d y=%0d len=%0d argb=%02h%02h%02h%02h last=%0d",
                     r.status, r.pos_x, r.pos_y, r.run_length, r.alpha, r.red,
                     r.green, r.blue, r.last_of_image);
  endfunction

  task automatic push_run(logic st, logic [15:0] x, logic [15:0] len,
                          logic [7:0] a, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    run_t item;
    item.status        = st;
    item.pos_x         = x[11:0];
    item.pos_y         = (st == STATUS_REJECTED) ? 12'd0 : row[11:0];
    item.run_length    = len[7:0];
    item.alpha         = a;
    item.red           = r;
    item.green         = g;
    item.blue          = b;
    item.last_of_image = (st == STATUS_RUN) && (x + len >= width) && (row == 16'd0);
    expected_runs.push_back(item);
  endtask

  task automatic begin_pixels();
    pix_word = '0;
    pix_idx  = '0;
    phase    = rle ? DEC_PACKET : DEC_PIXEL;
  endtask

  task automatic end_row();
    if (row == 16'd0) begin
      phase = DEC_DONE;
    end else begin
      row = row - 16'd1;
      col = '0;
    end
  endtask

  task automatic take_pixel(logic [7:0] b);
    logic [31:0] t;
    logic [7:0]  a, r, g, bl;
    logic [15:0] len;
    int unsigned size;
    size     = (depth == DEPTH_24) ? 3 : (depth == DEPTH_32) ? 4 : 2;
    pix_word = pix_word | (32'(b) << (8 * pix_idx[1:0]));
    pix_idx  = pix_idx + 3'd1;
    if (pix_idx < size) return;
    t        = pix_word;
    pix_word = '0;
    pix_idx  = '0;
    if (depth == DEPTH_15 || depth == DEPTH_16) begin
      r  = {t[14:10], 3'b000};
      g  = {t[9:5], 3'b000};
      bl = {t[4:0], 3'b000};
      a  = (depth == DEPTH_16 && t[15]) ? 8'h00 : 8'hff;
    end else begin
      bl = t[7:0];
      g  = t[15:8];
      r  = t[23:16];
      a  = (depth == DEPTH_32) ? t[31:24] : 8'hff;
    end
    if (!rle) begin
      push_run(STATUS_RUN, col, 16'd1, a, r, g, bl);
      col = col + 16'd1;
      if (col >= width) end_row();
    end else if (pkt_run) begin
      // A run is clipped at the row end and the rest of the packet is lost.
      len = width - col;
      if (16'(pkt_left) < len) len = 16'(pkt_left);
      push_run(STATUS_RUN, col, len, a, r, g, bl);
      col      = col + len;
      pkt_left = '0;
      if (col >= width) end_row();
      if (phase != DEC_DONE) phase = DEC_PACKET;
    end else begin
      // Raw pixels past the row end are read but give no run.
      if (col < width) begin
        push_run(STATUS_RUN, col, 16'd1, a, r, g, bl);
        col = col + 16'd1;
      end
      pkt_left = pkt_left - 8'd1;
      if (pkt_left == 8'd0) begin
        if (col >= width) end_row();
        if (phase != DEC_DONE) phase = DEC_PACKET;
      end
    end
  endtask

  task automatic decode_byte(logic [7:0] b, logic sof);
    if (sof) clear_decoder();
    case (phase)
      DEC_HEADER: begin
        case (hdr_idx)
          HDR_ID_LEN:    id_left = b;
          HDR_CMAP_TYPE: if (b != CMAP_NONE) hdr_bad = 1'b1;
          HDR_IMG_TYPE: begin
            if (b == TYPE_PLAIN) rle = 1'b0;
            else if (b == TYPE_RLE) rle = 1'b1;
            else hdr_bad = 1'b1;
          end
          HDR_WIDTH_LO:  width = {8'h00, b};
          HDR_WIDTH_HI:  width[15:8] = b;
          HDR_HEIGHT_LO: height = {8'h00, b};
          HDR_HEIGHT_HI: height[15:8] = b;
          HDR_DEPTH: begin
            case (b)
              BITS_15: depth = DEPTH_15;
              BITS_16: depth = DEPTH_16;
              BITS_24: depth = DEPTH_24;
              BITS_32: depth = DEPTH_32;
              default: hdr_bad = 1'b1;
            endcase
          end
          default: ;
        endcase
        if (hdr_idx < HDR_LAST) begin
          hdr_idx = hdr_idx + 5'd1;
        end else if (hdr_bad || width < MIN_SIDE || width > MAX_SIDE ||
                     height < MIN_SIDE || height > MAX_SIDE) begin
          phase = DEC_DONE;
          push_run(STATUS_REJECTED, '0, '0, '0, '0, '0, '0);
        end else begin
          col = '0;
          row = height - 16'd1;
          if (id_left != 8'd0) phase = DEC_SKIP_ID;
          else begin_pixels();
        end
      end
      DEC_SKIP_ID: begin
        id_left = id_left - 8'd1;
        if (id_left == 8'd0) begin_pixels();
      end
      DEC_PACKET: begin
        pkt_run  = b[7];
        pkt_left = {1'b0, b[6:0]} + 8'd1;
        pix_word = '0;
        pix_idx  = '0;
        phase    = DEC_PIXEL;
      end
      DEC_PIXEL: take_pixel(b);
      default: ;
    endcase
  endtask

  task automatic check_run();
    run_t got, want;
    got.status        = out_mon.status;
    got.pos_x         = out_mon.pos_x;
    got.pos_y         = out_mon.pos_y;
    got.run_length    = out_mon.run_length;
    got.alpha         = out_mon.alpha;
    got.red           = out_mon.red;
    got.green         = out_mon.green;
    got.blue          = out_mon.blue;
    got.last_of_image = out_mon.last_of_image;
    if (expected_runs.size() == 0) begin
      fails++;
      $display("%0t: run with none expected, actual %s", $time, describe(got));
    end else begin
      want = expected_runs.pop_front();
      if (got !== want) begin
        fails++;
        $display("%0t: run mismatch, expected %s, actual %s", $time, describe(want),
                 describe(got));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_decoder();
    end else begin
      if (in_mon.valid && in_mon.ready) decode_byte(in_mon.data_byte, in_mon.start_of_file);
      if (out_mon.valid && out_mon.ready) check_run();
    end
    runs_waiting_o <= expected_runs.size();
    fail_count_o   <= fails;
  end

endmodule

[verif/testbench.sv]
// Stimulus and verdict for the Targa true-colour RLE decoder.
`timescale 1ns / 1ps

module testbench;
  import tga_rle_pkg::*;
  import tga_file_pkg::*;

  // Roughly how many file bytes the whole run sends, ignored bytes aside.
  localparam int unsigned TOTAL_BYTES      = 1250;
  // The long receiver hold-off, and when it starts.
  localparam int unsigned HOLD_OFF_CYCLES  = 400;
  localparam int unsigned HOLD_AFTER_BYTES = 800;
  // Where each side's stretch without any idling begins.
  localparam int unsigned SEND_CALM_FROM   = 100;
  localparam int unsigned RECV_CALM_FROM   = 100;
  // Cycles without any transfer before the run is abandoned. The longest
  // legitimate silence is the hold-off, so this leaves a wide margin.
  localparam int unsigned STALL_LIMIT      = 5000;
  // How long to keep watching after the drain for any unexpected result.
  localparam int unsigned DRAIN_CYCLES     = 16;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tga_rle_in_if  in_if ();
  tga_rle_out_if out_if ();

  int unsigned fail_count;
  int unsigned runs_waiting;
  int unsigned bytes_sent   = 0;
  int unsigned counted_sent = 0;
  int unsigned runs_taken   = 0;
  bit          held_off     = 1'b0;

  // The file being assembled before it is sent.
  logic [7:0]  file_q[$];

  tga_truecolor_rle_decoder_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // The checker follows both channels on its own and only reports back how
  // many runs it still awaits and how many checks have failed.
  tga_run_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .fail_count_o   (fail_count),
    .runs_waiting_o (runs_waiting)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Each side idles with a chance of about seven in a hundred, except during a
  // stretch of three hundred units of progress in which it never idles.
  function automatic int unsigned idle_chance(int unsigned progress, int unsigned calm_from);
    return (progress >= calm_from && progress < calm_from + 300) ? 0 : 7;
  endfunction

  function automatic int unsigned bytes_per_pixel(logic [7:0] bits);
    return (bits == BITS_24) ? 3 : (bits == BITS_32) ? 4 : 2;
  endfunction

  // The 18 header bytes followed by the ID field. Fields the decoder does not
  // use (colour map spec, origin, descriptor) are filled at random.
  task automatic add_header(logic [7:0] id_len, logic [7:0] cmap, logic [7:0] img_type,
                            logic [15:0] w, logic [15:0] h, logic [7:0] bits);
    logic [7:0] hdr [HDR_BYTES];
    foreach (hdr[i]) hdr[i] = 8'($urandom());
    hdr[HDR_ID_LEN]    = id_len;
    hdr[HDR_CMAP_TYPE] = cmap;
    hdr[HDR_IMG_TYPE]  = img_type;
    hdr[HDR_WIDTH_LO]  = w[7:0];
    hdr[HDR_WIDTH_HI]  = w[15:8];
    hdr[HDR_HEIGHT_LO] = h[7:0];
    hdr[HDR_HEIGHT_HI] = h[15:8];
    hdr[HDR_DEPTH]     = bits;
    foreach (hdr[i]) file_q.push_back(hdr[i]);
    repeat (id_len) file_q.push_back(8'($urandom()));
  endtask

  // Pixels are stored little-endian, in as many bytes as the depth needs.
  task automatic add_pixel(logic [7:0] bits, logic [31:0] word);
    for (int unsigned i = 0; i < bytes_per_pixel(bits); i++) file_q.push_back(word[8*i +: 8]);
  endtask

  // A run packet carries one pixel; a raw packet carries one per count.
  task automatic add_packet(bit run, int unsigned cnt, logic [7:0] bits, logic [31:0] word);
    file_q.push_back({run, 7'(cnt - 1)});
    if (run) begin
      add_pixel(bits, word);
    end else begin
      repeat (cnt) add_pixel(bits, $urandom());
    end
  endtask

  task automatic add_plain_body(int unsigned pixels, logic [7:0] bits);
    repeat (pixels) add_pixel(bits, $urandom());
  endtask

  // Packets covering h rows of width w. Most packets fit in what is left of
  // the row; some overshoot it, so that runs are clipped and raw pixels are
  // dropped. A non-zero max_packets cuts the image short.
  task automatic add_rle_body(int unsigned w, int unsigned h, logic [7:0] bits,
                              int unsigned max_packets);
    int unsigned col, rows_left, cnt, room, packets;
    bit          run;
    col       = 0;
    rows_left = h;
    packets   = 0;
    while (rows_left != 0 && (max_packets == 0 || packets < max_packets)) begin
      room = w - col;
      run  = ($urandom_range(0, 99) < 65);
      if (run) begin
        cnt = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 128)
                                           : $urandom_range(1, (room > 128) ? 128 : room);
      end else if ($urandom_range(0, 99) < 15) begin
        cnt = room + $urandom_range(1, 4);
        if (cnt > 128) cnt = 128;
      end else begin
        cnt = $urandom_range(1, (room > 6) ? 6 : room);
      end
      add_packet(run, cnt, bits, $urandom());
      packets++;
      // The row only moves on at the end of a packet that filled it.
      if (cnt >= room) begin
        col = 0;
        rows_left--;
      end else begin
        col += cnt;
      end
    end
  endtask

  // One byte transfer. Valid drops only for an idle cycle, so back-to-back
  // bytes keep it high without a second assignment in the same time step.
  task automatic send_byte(logic [7:0] data, logic sof);
    while ($urandom_range(0, 99) < idle_chance(bytes_sent, SEND_CALM_FROM)) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= data;
    in_if.start_of_file <= sof;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
  endtask

  // Sends the assembled file; start_of_file marks its first byte if asked.
  // Bytes that the block is known to ignore are sent uncounted.
  task automatic send_file(bit with_sof, bit counted);
    foreach (file_q[i]) send_byte(file_q[i], with_sof && (i == 0));
    if (counted) counted_sent += file_q.size();
    file_q.delete();
  endtask

  // Stops offering bytes until every predicted run has been transferred.
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (runs_waiting != 0);
  endtask

  // Trailing bytes after a finished or rejected file must be ignored.
  task automatic send_junk();
    repeat ($urandom_range(0, 4)) file_q.push_back(8'($urandom()));
    send_file(1'b0, 1'b0);
  endtask

  initial begin : stimulus
    int unsigned kind, w, h, id_len;
    logic [7:0]  bits, img_type, cmap;
    logic [15:0] bad_w, bad_h;
    in_if.valid         <= 1'b0;
    in_if.data_byte     <= 8'h00;
    in_if.start_of_file <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The first file follows reset without start_of_file, so
    // it must still be read as a header. Its top row ends with a raw packet
    // that overshoots the row, the next row is a clipped 128-pixel run, and
    // every further row is one full-width run.
    add_header(8'd0, CMAP_NONE, TYPE_RLE, 16'd16, 16'd16, BITS_24);
    add_packet(1'b0, 14, BITS_24, $urandom());
    add_packet(1'b0, 5, BITS_24, $urandom());
    add_packet(1'b1, 128, BITS_24, $urandom());
    repeat (14) add_packet(1'b1, 16, BITS_24, $urandom());
    send_file(1'b0, 1'b1);
    send_junk();

    // The largest image, with an ID field, abandoned after its top row. That
    // row reaches the last column, and the extreme 16-bit pixels check the
    // alpha bit.
    add_header(8'd8, CMAP_NONE, TYPE_RLE, MAX_SIDE, MAX_SIDE, BITS_16);
    repeat (31) add_packet(1'b1, 128, BITS_16, $urandom());
    add_packet(1'b1, 127, BITS_16, 32'h0000_ffff);
    add_packet(1'b1, 1, BITS_16, 32'h0000_0000);
    send_file(1'b1, 1'b1);

    // Each reason for rejecting a header, one file each.
    add_header(8'd0, CMAP_PRESENT, TYPE_PLAIN, 16'd16, 16'd16, BITS_24);
    send_file(1'b1, 1'b1);
    add_header(8'd0, CMAP_NONE, TYPE_GREY, 16'd16, 16'd16, BITS_24);
    send_file(1'b1, 1'b1);
    add_header(8'd0, CMAP_NONE, TYPE_RLE, 16'd16, 16'd16, BITS_8);
    send_file(1'b1, 1'b1);
    add_header(8'd0, CMAP_NONE, TYPE_RLE, MIN_SIDE - 16'd1, 16'd16, BITS_32);
    send_file(1'b1, 1'b1);
    add_header(8'd0, CMAP_NONE, TYPE_RLE, MAX_SIDE + 16'd1, 16'd16, BITS_32);
    send_file(1'b1, 1'b1);
    add_header(8'd0, CMAP_NONE, TYPE_PLAIN, 16'd16, MIN_SIDE - 16'd1, BITS_15);
    send_file(1'b1, 1'b1);
    add_header(8'd0, CMAP_NONE, TYPE_PLAIN, 16'd16, MAX_SIDE + 16'd1, BITS_15);
    send_file(1'b1, 1'b1);
    add_header(8'd0, CMAP_NONE, TYPE_PLAIN, 16'hffff, 16'hffff, BITS_16);
    send_file(1'b1, 1'b1);
    send_junk();

    // A header cut short by the next start_of_file.
    add_header(8'd0, CMAP_NONE, TYPE_RLE, 16'd16, 16'd16, BITS_32);
    file_q = file_q[0:8];
    send_file(1'b1, 1'b1);

    // Let everything so far come out before going on.
    wait_for_drain();

    // The tallest uncompressed image, abandoned early, then a complete
    // uncompressed one, which gives a result every other byte and so is
    // where the receiver's long hold-off fills the block up.
    add_header(8'd0, CMAP_NONE, TYPE_PLAIN, MIN_SIDE, MAX_SIDE, BITS_32);
    add_plain_body(4, BITS_32);
    send_file(1'b1, 1'b1);
    add_header(8'd2, CMAP_NONE, TYPE_PLAIN, 16'd16, 16'd16, BITS_15);
    add_plain_body(256, BITS_15);
    send_file(1'b1, 1'b1);
    send_junk();

    // Random part, until the byte budget is spent: mostly well-formed RLE
    // images of small size, with cut short files, rejected headers and short
    // bursts of noise among them.
    while (counted_sent < TOTAL_BYTES) begin
      kind   = $urandom_range(0, 99);
      w      = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 64) : $urandom_range(16, 20);
      h      = $urandom_range(16, 18);
      id_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      case ($urandom_range(0, 3))
        0:       bits = BITS_15;
        1:       bits = BITS_16;
        2:       bits = BITS_24;
        default: bits = BITS_32;
      endcase
      if (kind < 55) begin
        add_header(8'(id_len), CMAP_NONE, TYPE_RLE, 16'(w), 16'(h), bits);
        add_rle_body(w, h, bits, 0);
        send_file(1'b1, 1'b1);
        send_junk();
      end else if (kind < 65) begin
        add_header(8'(id_len), CMAP_NONE, TYPE_RLE, 16'(w), 16'(h), bits);
        add_rle_body(w, h, bits, $urandom_range(1, 20));
        send_file(1'b1, 1'b1);
      end else if (kind < 75) begin
        add_header(8'(id_len), CMAP_NONE, TYPE_PLAIN, 16'(w), 16'(h), bits);
        add_plain_body($urandom_range(1, 40), bits);
        send_file(1'b1, 1'b1);
      end else if (kind < 88) begin
        // One field at a time is spoiled; the rest stays valid.
        cmap     = CMAP_NONE;
        img_type = ($urandom_range(0, 1) != 0) ? TYPE_RLE : TYPE_PLAIN;
        bad_w    = 16'(w);
        bad_h    = 16'(h);
        case ($urandom_range(0, 4))
          0:       cmap = 8'($urandom_range(1, 255));
          1:       do img_type = 8'($urandom()); while (img_type == TYPE_PLAIN ||
                                                        img_type == TYPE_RLE);
          2:       do bits = 8'($urandom()); while (bits == BITS_15 || bits == BITS_16 ||
                                                    bits == BITS_24 || bits == BITS_32);
          3:       bad_w = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, MIN_SIDE - 1))
                                                       : 16'($urandom_range(MAX_SIDE + 1, 16'hffff));
          default: bad_h = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, MIN_SIDE - 1))
                                                       : 16'($urandom_range(MAX_SIDE + 1, 16'hffff));
        endcase
        add_header(8'(id_len), cmap, img_type, bad_w, bad_h, bits);
        send_file(1'b1, 1'b1);
        send_junk();
      end else begin
        repeat ($urandom_range(1, 30)) file_q.push_back(8'($urandom()));
        send_file(1'b1, 1'b1);
      end
    end

    // Everything is sent: wait for the last runs, then a little longer in
    // case anything unexpected follows them.
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tga_truecolor_rle_decoder_unit: match");
    end else begin
      $display("tga_truecolor_rle_decoder_unit: mismatch");
    end
    $finish;
  end

  // The receiver takes runs with random stalls. Once, while the sender is
  // busy with an uncompressed image, it holds ready low for a long stretch,
  // so that the queue inside the block fills and the byte input stalls.
  initial begin : receiver
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) runs_taken++;
      if (!held_off && bytes_sent >= HOLD_AFTER_BYTES && out_if.valid) begin
        held_off = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= idle_chance(runs_taken, RECV_CALM_FROM));
      end
    end
  end

  // A run that hangs shows up as a long spell with no transfer on either side.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("tga_truecolor_rle_decoder_unit: mismatch");
    $finish;
  end

endmodule

[tga_truecolor_rle_decoder_unit.f]
rtl/core/tga_rle_pkg.sv
rtl/core/tga_rle_if.sv
rtl/core/tga_rle_front.sv
rtl/core/tga_rle_queue.sv
rtl/core/tga_rle_back.sv
rtl/core/tga_truecolor_rle_decoder_unit.sv
verif/tga_file_pkg.sv
verif/tga_run_checker.sv
verif/testbench.sv
